// File: design/cdp_pkg.sv
// cdp_pkg: shared types, register indexes and level lookup for the
// congestion degradation policy; no dependencies
package cdp_pkg;

    localparam int DEF_MAX_SLOTS  = 8;
    localparam int DEF_MAX_LEVELS = 8;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MONITOR_PRESENT = 3'd0,
        REG_SLOT_COUNT      = 3'd1,
        REG_LEVEL_COUNT     = 3'd2,
        REG_LEVELS_LOW      = 3'd3,
        REG_LEVELS_HIGH     = 3'd4,
        REG_HOLD_OFF        = 3'd5,
        REG_UPGRADE_CHANCE  = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_LO,
        ST_SCAN_HI,
        ST_CHECK,
        ST_MULT,
        ST_DOWN,
        ST_UP,
        ST_DONE
    } cdp_state_t;

    // 16-bit q8.8 level value out of the two level words
    function automatic logic [15:0] level_of(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [2:0] idx);
        logic [63:0] w;
        w = idx[2] ? hi : lo;
        return w[16*idx[1:0] +: 16];
    endfunction

endpackage

// File: design/congestion_degradation_policy.sv
// congestion_degradation_policy: top level, sequencer around one shared
// multiplier and one add/compare unit; depends on cdp_pkg
//
// usage:
//   s_ channel: one request beat = slot, level, capacity ratio, two times
//   and a random draw. m_ channel: one result beat = signed level change.
//   cfg channel: register index plus 64-bit data, always ready; write only
//   while no request is in flight.
// sequence:
//   a request walks the slots up to and including its own (one slot a
//   cycle through the hold-off adder), then, for a ratio above 256, the
//   slots above it, then a check state, a multiply state and a level walk
//   (one level a cycle, until a compare fails); any of these may end it
//   early. s_tready is low for the whole walk and rises again in the same
//   cycle as the result appears.
// reset:
//   aresetn low clears all per-slot state, the registers to their defaults
//   and the result valid flag.
// stall:
//   the result waits in an output register; a new request is taken while
//   it waits, and a second finished result holds the sequencer until the
//   first beat leaves.
module congestion_degradation_policy #(
    parameter int MAX_SLOTS  = cdp_pkg::DEF_MAX_SLOTS,
    parameter int MAX_LEVELS = cdp_pkg::DEF_MAX_LEVELS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request: slot_index[2:0], current_level[5:3], cap_ratio[21:6],
    // measure_time[53:22], now_time[85:54], random_draw[101:86], zero pad
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cdp_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result: level_delta[3:0] signed, zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cdp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cdp_pkg::*;

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    // configuration registers
    logic        mon_reg;
    logic [3:0]  slot_cnt_reg;
    logic [3:0]  lvl_cnt_reg;
    logic [63:0] lvl_lo_reg;
    logic [63:0] lvl_hi_reg;
    logic [15:0] hold_reg;
    logic [15:0] chance_reg;

    // per-slot state
    logic [31:0] lct_reg  [MAX_SLOTS];
    logic [31:0] lchk_reg [MAX_SLOTS];
    logic [2:0]  sdf_reg  [MAX_SLOTS];
    logic [2:0]  suf_reg  [MAX_SLOTS];

    // request latch
    logic [2:0]  slot_reg;
    logic [2:0]  cur_reg;
    logic [15:0] c_reg;
    logic [31:0] meas_reg;
    logic [31:0] now_reg;
    logic [15:0] draw_reg;

    // working registers
    cdp_state_t  state_reg, state_next;
    logic [SW-1:0] idx_reg;
    logic [2:0]  t_reg;
    logic [3:0]  ms_reg;
    logic [31:0] prod_reg;
    logic        upd_reg;
    logic        m_tvalid_reg;
    logic [3:0]  delta_reg;

    logic        s_accept;
    logic        out_free;

    // clamped counts
    logic [4:0]  n_eff;
    logic [3:0]  lc_eff;
    logic [4:0]  slot_x;
    logic [4:0]  idx_x;
    logic [SW-1:0] slot_i;

    assign n_eff  = ({1'b0, slot_cnt_reg} > 5'(MAX_SLOTS)) ? 5'(MAX_SLOTS)
                                                           : {1'b0, slot_cnt_reg};
    assign lc_eff = (lvl_cnt_reg == 4'd0) ? 4'd1 :
                    (lvl_cnt_reg > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : lvl_cnt_reg;
    assign slot_x = {2'b00, slot_reg};
    assign idx_x  = 5'(idx_reg);
    assign slot_i = SW'(slot_reg);

    // shared hold-off adder and compare
    logic [32:0] hold_sum;
    logic        held;
    assign hold_sum = {1'b0, lct_reg[idx_reg]} + 33'(hold_reg);
    assign held     = hold_sum > {1'b0, meas_reg};

    // level walk compares
    logic [15:0] lvl_t, lvl_ms, lvl_cur;
    logic [36:0] down_lhs, down_rhs;
    logic        down_go, up_go;
    logic [4:0]  mid_sum;
    assign lvl_t    = level_of(lvl_lo_reg, lvl_hi_reg, t_reg);
    assign lvl_ms   = level_of(lvl_lo_reg, lvl_hi_reg, ms_reg[2:0]);
    assign lvl_cur  = level_of(lvl_lo_reg, lvl_hi_reg, cur_reg);
    // 20 * c * l[cur] against 19 * 256 * l[t]
    assign down_lhs = (37'(prod_reg) << 4) + (37'(prod_reg) << 2);
    assign down_rhs = (37'(lvl_t) << 12) + (37'(lvl_t) << 9) + (37'(lvl_t) << 8);
    assign down_go  = (t_reg != 3'd0) && (down_lhs < down_rhs);
    assign up_go    = (ms_reg < lc_eff) && ({8'h00, lvl_ms, 8'h00} < prod_reg);
    assign mid_sum  = 5'(ms_reg) + 5'(cur_reg) + 5'd1;

    logic        checked;
    assign checked = lchk_reg[slot_i] > lct_reg[slot_i];

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (!mon_reg || n_eff == 5'd0 || {2'b00, s_tdata[2:0]} >= n_eff) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN_LO;
                    end
                end
            end
            ST_SCAN_LO: begin
                if (held && c_reg != 16'd0) begin
                    state_next = ST_DONE;
                end else if (idx_x == slot_x) begin
                    if (c_reg > 16'd256 && n_eff - 5'd1 > slot_x) begin
                        state_next = ST_SCAN_HI;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end else if (c_reg < 16'd256 && sdf_reg[idx_reg] != 3'd0) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN_HI: begin
                if (suf_reg[idx_reg] != 3'd0 || held) begin
                    state_next = ST_DONE;
                end else if (idx_x - 5'd1 == slot_x) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!checked || {1'b0, cur_reg} >= lc_eff) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                if (c_reg <= 16'd243) begin
                    state_next = ST_DOWN;
                end else if (c_reg >= 16'd282 && {1'b0, cur_reg} < lc_eff - 4'd1
                             && cur_reg != 3'd0) begin
                    state_next = ST_UP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DOWN: begin
                if (!down_go) begin
                    state_next = ST_DONE;
                end
            end
            ST_UP: begin
                if (!up_go) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        s_accept = s_tvalid && s_tready;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'h0, delta_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            mon_reg      <= 1'b0;
            slot_cnt_reg <= 4'd0;
            lvl_cnt_reg  <= 4'd1;
            lvl_lo_reg   <= 64'd0;
            lvl_hi_reg   <= 64'd0;
            hold_reg     <= 16'd1000;
            chance_reg   <= 16'd3277;
            upd_reg      <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                lct_reg[i]  <= 32'd0;
                lchk_reg[i] <= 32'd0;
                sdf_reg[i]  <= 3'd0;
                suf_reg[i]  <= 3'd0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MONITOR_PRESENT: mon_reg      <= cfg_data[0];
                    REG_SLOT_COUNT:      slot_cnt_reg <= cfg_data[3:0];
                    REG_LEVEL_COUNT:     lvl_cnt_reg  <= cfg_data[3:0];
                    REG_LEVELS_LOW:      lvl_lo_reg   <= cfg_data;
                    REG_LEVELS_HIGH:     lvl_hi_reg   <= cfg_data;
                    REG_HOLD_OFF:        hold_reg     <= cfg_data[15:0];
                    REG_UPGRADE_CHANCE:  chance_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // a finished result loads the output register once it is free
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    upd_reg <= 1'b0;
                    idx_reg <= '0;
                end
                ST_SCAN_LO: begin
                    if (idx_x == slot_x) begin
                        idx_reg <= SW'(n_eff - 5'd1);
                    end else begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                ST_SCAN_HI: begin
                    idx_reg <= idx_reg - SW'(1);
                end
                ST_CHECK: begin
                    // check time recorded before the level range test
                    lchk_reg[slot_i] <= meas_reg;
                end
                ST_MULT: begin
                    // the one multiply of a request
                    prod_reg <= c_reg * lvl_cur;
                    upd_reg  <= 1'b1;
                    ms_reg   <= {1'b0, cur_reg};
                    if (c_reg >= 16'd282 && {1'b0, cur_reg} < lc_eff - 4'd1
                        && cur_reg == 3'd0) begin
                        t_reg <= 3'd1;
                    end else begin
                        t_reg <= cur_reg;
                    end
                end
                ST_DOWN: begin
                    if (down_go) begin
                        t_reg <= t_reg - 3'd1;
                    end
                end
                ST_UP: begin
                    if (up_go) begin
                        ms_reg <= ms_reg + 4'd1;
                    end else if (draw_reg < chance_reg) begin
                        t_reg <= mid_sum[3:1];
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        if (upd_reg) begin
                            if (t_reg != cur_reg) begin
                                lct_reg[slot_i] <= now_reg;
                            end
                            sdf_reg[slot_i] <= t_reg;
                            suf_reg[slot_i] <= 3'(lc_eff - {1'b0, t_reg} - 4'd1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            slot_reg <= s_tdata[2:0];
            cur_reg  <= s_tdata[5:3];
            c_reg    <= s_tdata[21:6];
            meas_reg <= s_tdata[53:22];
            now_reg  <= s_tdata[85:54];
            draw_reg <= s_tdata[101:86];
        end
        if (state_reg == ST_DONE && out_free) begin
            delta_reg <= upd_reg ? 4'({1'b0, t_reg} - {1'b0, cur_reg}) : 4'd0;
        end
    end

endmodule

// File: design/cdp_checker.sv
// cdp_checker: port-level checks for congestion_degradation_policy, bound
// to the top level; depends on cdp_pkg
module cdp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cdp_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            cfg_ready
);
    import cdp_pkg::*;

    // s_tready is low in the cycle after a request beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready stayed high after a request beat");

    // a result appears only after the sequencer was busy
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result beat without a request in flight");

    // level change stays in range and padding is zero
    a_delta_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:4] == 4'h0 && m_tdata[3:0] != 4'h8))
        else $error("level change out of range");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration channel not ready");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

endmodule

bind congestion_degradation_policy cdp_checker u_cdp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
